>>> hdl/escu_pkg.sv
// Package for the environmental sensor compensation unit: types, constants and the step ROM.
`timescale 1ns / 1ps
package escu_pkg;

   // Measurement kinds carried on req_op
   localparam logic [1:0] OP_TEMP  = 2'd0;
   localparam logic [1:0] OP_PRESS = 2'd1;
   localparam logic [1:0] OP_HUM   = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DISABLED = 2'd1;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_TEMP    = 3'd0;
   localparam logic [2:0] CSR_PRESS_A = 3'd1;
   localparam logic [2:0] CSR_PRESS_B = 3'd2;
   localparam logic [2:0] CSR_PRESS_C = 3'd3;
   localparam logic [2:0] CSR_HUM     = 3'd4;

   localparam logic [23:0] TP_SKIP_MARKER  = 24'h800000;
   localparam logic [15:0] HUM_SKIP_MARKER = 16'h8000;
   localparam logic [31:0] HUM_LIMIT       = 32'd419430400;

   localparam int PC_W = 7;
   localparam logic [PC_W-1:0] PC_TEMP  = 7'd0;
   localparam logic [PC_W-1:0] PC_PRESS = 7'd15;
   localparam logic [PC_W-1:0] PC_HUM   = 7'd47;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      UOP_ADD,
      UOP_SUB,
      UOP_SHL,
      UOP_ASR,
      UOP_MUL,
      UOP_DIV
   } uop_op_type;

   typedef enum logic [5:0] {
      SRC_R0, SRC_R1, SRC_R2, SRC_R3,
      SRC_ADC, SRC_HADC, SRC_FT,
      SRC_T1, SRC_T2, SRC_T3,
      SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9,
      SRC_H1, SRC_H2, SRC_H3, SRC_H4, SRC_H5, SRC_H6,
      SRC_K5, SRC_K128, SRC_K128000, SRC_K1048576, SRC_K3125, SRC_K76800,
      SRC_K16384, SRC_K32768, SRC_K2097152, SRC_K8192, SRC_K2P47,
      SRC_ZERO
   } src_type;

   typedef struct packed {
      uop_op_type op;
      logic [1:0] dst;
      src_type    src_a;
      src_type    src_b;
      logic [5:0] sh;
      logic       w32;
      logic       last;
   } uop_type;

   localparam logic W32 = 1'b1;
   localparam logic W64 = 1'b0;

   function automatic uop_type mk(input uop_op_type op, input logic [1:0] dst,
                                  input src_type a, input src_type b,
                                  input logic [5:0] sh, input logic w32,
                                  input logic last);
      uop_type u;
      u.op    = op;
      u.dst   = dst;
      u.src_a = a;
      u.src_b = b;
      u.sh    = sh;
      u.w32   = w32;
      u.last  = last;
      return u;
   endfunction

   // Step program: temperature, then pressure, then humidity.
   function automatic uop_type uop_rom(input logic [PC_W-1:0] addr);
      uop_type u;
      u = mk(UOP_ADD, 2'd0, SRC_ZERO, SRC_ZERO, 6'd0, W64, 1'b1);
      case (addr)
         // Temperature
         7'd0:  u = mk(UOP_ASR, 2'd0, SRC_ADC, SRC_ZERO, 6'd3, W32, 1'b0);
         7'd1:  u = mk(UOP_SHL, 2'd1, SRC_T1, SRC_ZERO, 6'd1, W32, 1'b0);
         7'd2:  u = mk(UOP_SUB, 2'd0, SRC_R0, SRC_R1, 6'd0, W32, 1'b0);
         7'd3:  u = mk(UOP_MUL, 2'd0, SRC_R0, SRC_T2, 6'd0, W32, 1'b0);
         7'd4:  u = mk(UOP_ASR, 2'd0, SRC_R0, SRC_ZERO, 6'd11, W32, 1'b0);
         7'd5:  u = mk(UOP_ASR, 2'd1, SRC_ADC, SRC_ZERO, 6'd4, W32, 1'b0);
         7'd6:  u = mk(UOP_SUB, 2'd1, SRC_R1, SRC_T1, 6'd0, W32, 1'b0);
         7'd7:  u = mk(UOP_MUL, 2'd1, SRC_R1, SRC_R1, 6'd0, W32, 1'b0);
         7'd8:  u = mk(UOP_ASR, 2'd1, SRC_R1, SRC_ZERO, 6'd12, W32, 1'b0);
         7'd9:  u = mk(UOP_MUL, 2'd1, SRC_R1, SRC_T3, 6'd0, W32, 1'b0);
         7'd10: u = mk(UOP_ASR, 2'd1, SRC_R1, SRC_ZERO, 6'd14, W32, 1'b0);
         7'd11: u = mk(UOP_ADD, 2'd0, SRC_R0, SRC_R1, 6'd0, W32, 1'b0);
         7'd12: u = mk(UOP_MUL, 2'd1, SRC_R0, SRC_K5, 6'd0, W32, 1'b0);
         7'd13: u = mk(UOP_ADD, 2'd1, SRC_R1, SRC_K128, 6'd0, W32, 1'b0);
         7'd14: u = mk(UOP_ASR, 2'd1, SRC_R1, SRC_ZERO, 6'd8, W32, 1'b1);
         // Pressure
         7'd15: u = mk(UOP_SUB, 2'd0, SRC_FT, SRC_K128000, 6'd0, W64, 1'b0);
         7'd16: u = mk(UOP_MUL, 2'd1, SRC_R0, SRC_R0, 6'd0, W64, 1'b0);
         7'd17: u = mk(UOP_MUL, 2'd2, SRC_R1, SRC_P6, 6'd0, W64, 1'b0);
         7'd18: u = mk(UOP_MUL, 2'd3, SRC_R0, SRC_P5, 6'd0, W64, 1'b0);
         7'd19: u = mk(UOP_SHL, 2'd3, SRC_R3, SRC_ZERO, 6'd17, W64, 1'b0);
         7'd20: u = mk(UOP_ADD, 2'd2, SRC_R2, SRC_R3, 6'd0, W64, 1'b0);
         7'd21: u = mk(UOP_SHL, 2'd3, SRC_P4, SRC_ZERO, 6'd35, W64, 1'b0);
         7'd22: u = mk(UOP_ADD, 2'd2, SRC_R2, SRC_R3, 6'd0, W64, 1'b0);
         7'd23: u = mk(UOP_MUL, 2'd1, SRC_R1, SRC_P3, 6'd0, W64, 1'b0);
         7'd24: u = mk(UOP_ASR, 2'd1, SRC_R1, SRC_ZERO, 6'd8, W64, 1'b0);
         7'd25: u = mk(UOP_MUL, 2'd3, SRC_R0, SRC_P2, 6'd0, W64, 1'b0);
         7'd26: u = mk(UOP_SHL, 2'd3, SRC_R3, SRC_ZERO, 6'd12, W64, 1'b0);
         7'd27: u = mk(UOP_ADD, 2'd1, SRC_R1, SRC_R3, 6'd0, W64, 1'b0);
         7'd28: u = mk(UOP_ADD, 2'd0, SRC_K2P47, SRC_R1, 6'd0, W64, 1'b0);
         7'd29: u = mk(UOP_MUL, 2'd0, SRC_R0, SRC_P1, 6'd0, W64, 1'b0);
         7'd30: u = mk(UOP_ASR, 2'd0, SRC_R0, SRC_ZERO, 6'd33, W64, 1'b0);
         7'd31: u = mk(UOP_SUB, 2'd1, SRC_K1048576, SRC_ADC, 6'd0, W64, 1'b0);
         7'd32: u = mk(UOP_SHL, 2'd1, SRC_R1, SRC_ZERO, 6'd31, W64, 1'b0);
         7'd33: u = mk(UOP_SUB, 2'd1, SRC_R1, SRC_R2, 6'd0, W64, 1'b0);
         7'd34: u = mk(UOP_MUL, 2'd1, SRC_R1, SRC_K3125, 6'd0, W64, 1'b0);
         7'd35: u = mk(UOP_DIV, 2'd1, SRC_R1, SRC_R0, 6'd0, W64, 1'b0);
         7'd36: u = mk(UOP_ASR, 2'd3, SRC_R1, SRC_ZERO, 6'd13, W64, 1'b0);
         7'd37: u = mk(UOP_MUL, 2'd2, SRC_P9, SRC_R3, 6'd0, W64, 1'b0);
         7'd38: u = mk(UOP_MUL, 2'd2, SRC_R2, SRC_R3, 6'd0, W64, 1'b0);
         7'd39: u = mk(UOP_ASR, 2'd2, SRC_R2, SRC_ZERO, 6'd25, W64, 1'b0);
         7'd40: u = mk(UOP_MUL, 2'd3, SRC_P8, SRC_R1, 6'd0, W64, 1'b0);
         7'd41: u = mk(UOP_ASR, 2'd3, SRC_R3, SRC_ZERO, 6'd19, W64, 1'b0);
         7'd42: u = mk(UOP_ADD, 2'd1, SRC_R1, SRC_R2, 6'd0, W64, 1'b0);
         7'd43: u = mk(UOP_ADD, 2'd1, SRC_R1, SRC_R3, 6'd0, W64, 1'b0);
         7'd44: u = mk(UOP_ASR, 2'd1, SRC_R1, SRC_ZERO, 6'd8, W64, 1'b0);
         7'd45: u = mk(UOP_SHL, 2'd3, SRC_P7, SRC_ZERO, 6'd4, W64, 1'b0);
         7'd46: u = mk(UOP_ADD, 2'd1, SRC_R1, SRC_R3, 6'd0, W64, 1'b1);
         // Humidity
         7'd47: u = mk(UOP_SUB, 2'd0, SRC_FT, SRC_K76800, 6'd0, W32, 1'b0);
         7'd48: u = mk(UOP_SHL, 2'd1, SRC_HADC, SRC_ZERO, 6'd14, W32, 1'b0);
         7'd49: u = mk(UOP_SHL, 2'd2, SRC_H4, SRC_ZERO, 6'd20, W32, 1'b0);
         7'd50: u = mk(UOP_SUB, 2'd1, SRC_R1, SRC_R2, 6'd0, W32, 1'b0);
         7'd51: u = mk(UOP_MUL, 2'd2, SRC_H5, SRC_R0, 6'd0, W32, 1'b0);
         7'd52: u = mk(UOP_SUB, 2'd1, SRC_R1, SRC_R2, 6'd0, W32, 1'b0);
         7'd53: u = mk(UOP_ADD, 2'd1, SRC_R1, SRC_K16384, 6'd0, W32, 1'b0);
         7'd54: u = mk(UOP_ASR, 2'd1, SRC_R1, SRC_ZERO, 6'd15, W32, 1'b0);
         7'd55: u = mk(UOP_MUL, 2'd2, SRC_R0, SRC_H6, 6'd0, W32, 1'b0);
         7'd56: u = mk(UOP_ASR, 2'd2, SRC_R2, SRC_ZERO, 6'd10, W32, 1'b0);
         7'd57: u = mk(UOP_MUL, 2'd3, SRC_R0, SRC_H3, 6'd0, W32, 1'b0);
         7'd58: u = mk(UOP_ASR, 2'd3, SRC_R3, SRC_ZERO, 6'd11, W32, 1'b0);
         7'd59: u = mk(UOP_ADD, 2'd3, SRC_R3, SRC_K32768, 6'd0, W32, 1'b0);
         7'd60: u = mk(UOP_MUL, 2'd2, SRC_R2, SRC_R3, 6'd0, W32, 1'b0);
         7'd61: u = mk(UOP_ASR, 2'd2, SRC_R2, SRC_ZERO, 6'd10, W32, 1'b0);
         7'd62: u = mk(UOP_ADD, 2'd2, SRC_R2, SRC_K2097152, 6'd0, W32, 1'b0);
         7'd63: u = mk(UOP_MUL, 2'd2, SRC_R2, SRC_H2, 6'd0, W32, 1'b0);
         7'd64: u = mk(UOP_ADD, 2'd2, SRC_R2, SRC_K8192, 6'd0, W32, 1'b0);
         7'd65: u = mk(UOP_ASR, 2'd2, SRC_R2, SRC_ZERO, 6'd14, W32, 1'b0);
         7'd66: u = mk(UOP_MUL, 2'd0, SRC_R1, SRC_R2, 6'd0, W32, 1'b0);
         7'd67: u = mk(UOP_ASR, 2'd1, SRC_R0, SRC_ZERO, 6'd15, W32, 1'b0);
         7'd68: u = mk(UOP_MUL, 2'd1, SRC_R1, SRC_R1, 6'd0, W32, 1'b0);
         7'd69: u = mk(UOP_ASR, 2'd1, SRC_R1, SRC_ZERO, 6'd7, W32, 1'b0);
         7'd70: u = mk(UOP_MUL, 2'd1, SRC_R1, SRC_H1, 6'd0, W32, 1'b0);
         7'd71: u = mk(UOP_ASR, 2'd1, SRC_R1, SRC_ZERO, 6'd4, W32, 1'b0);
         7'd72: u = mk(UOP_SUB, 2'd0, SRC_R0, SRC_R1, 6'd0, W32, 1'b1);
         default: u = mk(UOP_ADD, 2'd0, SRC_ZERO, SRC_ZERO, 6'd0, W64, 1'b1);
      endcase
      return u;
   endfunction

endpackage

>>> hdl/escu_mul.sv
// Shared multiplier: low 64 bits of a 64 x 64 product from three 32 x 32 partial products.
`timescale 1ns / 1ps
module escu_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  phase_ff, phase_in;
   logic [63:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [31:0] mx, my;
   logic [63:0] part;

   // Phase 0 takes the low halves; phases 1 and 2 only add their low word at bit 32.
   always_comb begin
      case (phase_ff)
         2'd0: begin
            mx = a_ff[31:0];
            my = b_ff[31:0];
         end
         2'd1: begin
            mx = a_ff[31:0];
            my = b_ff[63:32];
         end
         default: begin
            mx = a_ff[63:32];
            my = b_ff[31:0];
         end
      endcase
      part = 64'(mx) * 64'(my);
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 2'd0;
         a_in     = op_a;
         b_in     = op_b;
      end else if (busy_ff) begin
         if (phase_ff == 2'd0) begin
            acc_in = part;
         end else begin
            acc_in = acc_ff + {part[31:0], 32'd0};
         end
         phase_in = phase_ff + 2'd1;
         if (phase_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

>>> hdl/escu_div.sv
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module escu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [64:0] shifted, trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quo_ff[63]};
      trial   = shifted - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd63;
         rem_in  = 64'd0;
         neg_in  = dividend[63] ^ divisor[63];
         quo_in  = dividend[63] ? (64'd0 - dividend) : dividend;
         den_in  = divisor[63] ? (64'd0 - divisor) : divisor;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (64'd0 - quo_ff) : quo_ff;

endmodule

>>> hdl/environmental_sensor_compensation_unit.sv
// Top level of the environmental sensor compensation unit: step sequencer and shared datapath.
`timescale 1ns / 1ps
// Each transaction on the req_ channel carries one raw reading and its kind; the unit answers
// with exactly one rsp_ transaction. A small sequencer walks a fixed step program through one
// shared adder/shifter, a multiplier and a one-bit-per-cycle divider, and takes no
// new reading until the current one has finished. Temperature is the shortest and pressure
// the longest, most of it the division; a disabled-measurement marker, an unused kind or a
// zero pressure divisor finishes at once or early. The finished result sits in an output
// register, so a new reading is taken while it waits to be collected. The user must write
// calibration registers through csr_ only while the unit is idle; the unit does not enforce it.
module environmental_sensor_compensation_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [23:0]        req_raw_reading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   escu_pkg::state_type state_ff, state_in;
   logic [escu_pkg::PC_W-1:0] pc_ff, pc_in;
   logic [1:0]  kind_ff;
   logic [23:0] raw_ff;
   logic [31:0] fine_ff;
   logic [63:0] r0_ff, r1_ff, r2_ff, r3_ff;
   logic [47:0] temp_coeffs_ff, press_a_ff, press_b_ff, press_c_ff;
   logic [63:0] hum_coeffs_ff;
   logic [31:0] res_value_ff, res_value_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;

   escu_pkg::uop_type uop;
   logic [63:0] opa, opb, alu, wb_raw, wb_data;
   logic        req_accept, skip, rsp_load;
   logic        mul_start, div_start, mul_done, div_done;
   logic        wb_en, finish, div_zero;
   logic [63:0] mul_p, div_q;
   logic [31:0] hum_clamped;

   function automatic logic [63:0] sel_src(input escu_pkg::src_type s,
                                           input logic [63:0] r0, input logic [63:0] r1,
                                           input logic [63:0] r2, input logic [63:0] r3,
                                           input logic [23:0] raw, input logic [31:0] ft,
                                           input logic [47:0] tc, input logic [47:0] pa,
                                           input logic [47:0] pb, input logic [47:0] pcf,
                                           input logic [63:0] hc);
      logic [63:0] v;
      case (s)
         escu_pkg::SRC_R0:       v = r0;
         escu_pkg::SRC_R1:       v = r1;
         escu_pkg::SRC_R2:       v = r2;
         escu_pkg::SRC_R3:       v = r3;
         escu_pkg::SRC_ADC:      v = {44'd0, raw[23:4]};
         escu_pkg::SRC_HADC:     v = {48'd0, raw[15:0]};
         escu_pkg::SRC_FT:       v = {{32{ft[31]}}, ft};
         escu_pkg::SRC_T1:       v = {48'd0, tc[15:0]};
         escu_pkg::SRC_T2:       v = {{48{tc[31]}}, tc[31:16]};
         escu_pkg::SRC_T3:       v = {{48{tc[47]}}, tc[47:32]};
         escu_pkg::SRC_P1:       v = {48'd0, pa[15:0]};
         escu_pkg::SRC_P2:       v = {{48{pa[31]}}, pa[31:16]};
         escu_pkg::SRC_P3:       v = {{48{pa[47]}}, pa[47:32]};
         escu_pkg::SRC_P4:       v = {{48{pb[15]}}, pb[15:0]};
         escu_pkg::SRC_P5:       v = {{48{pb[31]}}, pb[31:16]};
         escu_pkg::SRC_P6:       v = {{48{pb[47]}}, pb[47:32]};
         escu_pkg::SRC_P7:       v = {{48{pcf[15]}}, pcf[15:0]};
         escu_pkg::SRC_P8:       v = {{48{pcf[31]}}, pcf[31:16]};
         escu_pkg::SRC_P9:       v = {{48{pcf[47]}}, pcf[47:32]};
         escu_pkg::SRC_H1:       v = {56'd0, hc[7:0]};
         escu_pkg::SRC_H2:       v = {{48{hc[23]}}, hc[23:8]};
         escu_pkg::SRC_H3:       v = {56'd0, hc[31:24]};
         escu_pkg::SRC_H4:       v = {{52{hc[43]}}, hc[43:32]};
         escu_pkg::SRC_H5:       v = {{52{hc[55]}}, hc[55:44]};
         escu_pkg::SRC_H6:       v = {{56{hc[63]}}, hc[63:56]};
         escu_pkg::SRC_K5:       v = 64'd5;
         escu_pkg::SRC_K128:     v = 64'd128;
         escu_pkg::SRC_K128000:  v = 64'd128000;
         escu_pkg::SRC_K1048576: v = 64'd1048576;
         escu_pkg::SRC_K3125:    v = 64'd3125;
         escu_pkg::SRC_K76800:   v = 64'd76800;
         escu_pkg::SRC_K16384:   v = 64'd16384;
         escu_pkg::SRC_K32768:   v = 64'd32768;
         escu_pkg::SRC_K2097152: v = 64'd2097152;
         escu_pkg::SRC_K8192:    v = 64'd8192;
         escu_pkg::SRC_K2P47:    v = 64'h0000_8000_0000_0000;
         default:                v = 64'd0;
      endcase
      return v;
   endfunction

   assign req_stall  = (state_ff != escu_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign uop        = escu_pkg::uop_rom(pc_ff);

   always_comb begin
      case (req_op)
         escu_pkg::OP_TEMP, escu_pkg::OP_PRESS: begin
            skip = (req_raw_reading == escu_pkg::TP_SKIP_MARKER);
         end
         escu_pkg::OP_HUM: skip = (req_raw_reading[15:0] == escu_pkg::HUM_SKIP_MARKER);
         default:          skip = 1'b1;
      endcase
   end

   always_comb begin
      opa = sel_src(uop.src_a, r0_ff, r1_ff, r2_ff, r3_ff, raw_ff, fine_ff,
                    temp_coeffs_ff, press_a_ff, press_b_ff, press_c_ff, hum_coeffs_ff);
      opb = sel_src(uop.src_b, r0_ff, r1_ff, r2_ff, r3_ff, raw_ff, fine_ff,
                    temp_coeffs_ff, press_a_ff, press_b_ff, press_c_ff, hum_coeffs_ff);
   end

   always_comb begin
      case (uop.op)
         escu_pkg::UOP_ADD: alu = opa + opb;
         escu_pkg::UOP_SUB: alu = opa - opb;
         escu_pkg::UOP_SHL: alu = opa << uop.sh;
         escu_pkg::UOP_ASR: alu = 64'($signed(opa) >>> uop.sh);
         default:           alu = opa;
      endcase
      if (state_ff == escu_pkg::ST_WAIT) begin
         wb_raw = (uop.op == escu_pkg::UOP_DIV) ? div_q : mul_p;
      end else begin
         wb_raw = alu;
      end
      // Temperature and humidity wrap at 32 bits; keeping them sign-extended makes the
      // 64-bit arithmetic shift behave as the 32-bit one.
      wb_data = uop.w32 ? {{32{wb_raw[31]}}, wb_raw[31:0]} : wb_raw;
   end

   always_comb begin
      if (wb_data[31]) begin
         hum_clamped = 32'd0;
      end else if (wb_data[31:0] > escu_pkg::HUM_LIMIT) begin
         hum_clamped = escu_pkg::HUM_LIMIT >> 12;
      end else begin
         hum_clamped = wb_data[31:0] >> 12;
      end
   end

   // Sequencer outputs
   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      wb_en     = 1'b0;
      div_zero  = 1'b0;
      unique case (state_ff)
         escu_pkg::ST_ISSUE: begin
            case (uop.op)
               escu_pkg::UOP_MUL: mul_start = 1'b1;
               escu_pkg::UOP_DIV: begin
                  div_zero  = (opb == 64'd0);
                  div_start = (opb != 64'd0);
               end
               default: wb_en = 1'b1;
            endcase
         end
         escu_pkg::ST_WAIT: wb_en = mul_done || div_done;
         default: wb_en = 1'b0;
      endcase
      finish   = wb_en && uop.last;
      rsp_load = (state_ff == escu_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         escu_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = skip ? escu_pkg::ST_DONE : escu_pkg::ST_ISSUE;
            end
         end
         escu_pkg::ST_ISSUE: begin
            if (div_zero || finish) begin
               state_in = escu_pkg::ST_DONE;
            end else if (mul_start || div_start) begin
               state_in = escu_pkg::ST_WAIT;
            end
         end
         escu_pkg::ST_WAIT: begin
            if (finish) begin
               state_in = escu_pkg::ST_DONE;
            end else if (wb_en) begin
               state_in = escu_pkg::ST_ISSUE;
            end
         end
         escu_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = escu_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      pc_in         = pc_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      if (req_accept) begin
         res_value_in  = 32'd0;
         res_status_in = (req_op == escu_pkg::OP_NONE) ? escu_pkg::STATUS_OK
                                                      : escu_pkg::STATUS_DISABLED;
         case (req_op)
            escu_pkg::OP_TEMP:  pc_in = escu_pkg::PC_TEMP;
            escu_pkg::OP_PRESS: pc_in = escu_pkg::PC_PRESS;
            default:            pc_in = escu_pkg::PC_HUM;
         endcase
      end else if (div_zero) begin
         res_value_in  = 32'd0;
         res_status_in = escu_pkg::STATUS_DIV_ZERO;
      end else if (finish) begin
         res_status_in = escu_pkg::STATUS_OK;
         res_value_in  = (kind_ff == escu_pkg::OP_HUM) ? hum_clamped : wb_data[31:0];
      end else if (wb_en) begin
         pc_in = pc_ff + 7'd1;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= escu_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         fine_ff        <= 32'd0;
         temp_coeffs_ff <= 48'd0;
         press_a_ff     <= 48'd0;
         press_b_ff     <= 48'd0;
         press_c_ff     <= 48'd0;
         hum_coeffs_ff  <= 64'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish && (kind_ff == escu_pkg::OP_TEMP)) begin
            fine_ff <= r0_ff[31:0];
         end
         if (csr_we) begin
            unique case (csr_index)
               escu_pkg::CSR_TEMP:    temp_coeffs_ff <= csr_wdata[47:0];
               escu_pkg::CSR_PRESS_A: press_a_ff     <= csr_wdata[47:0];
               escu_pkg::CSR_PRESS_B: press_b_ff     <= csr_wdata[47:0];
               escu_pkg::CSR_PRESS_C: press_c_ff     <= csr_wdata[47:0];
               escu_pkg::CSR_HUM:     hum_coeffs_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pc_ff         <= pc_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (req_accept) begin
         kind_ff <= req_op;
         raw_ff  <= req_raw_reading;
      end
      if (wb_en) begin
         case (uop.dst)
            2'd0:    r0_ff <= wb_data;
            2'd1:    r1_ff <= wb_data;
            2'd2:    r2_ff <= wb_data;
            default: r3_ff <= wb_data;
         endcase
      end
      if (rsp_load) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   escu_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (opa),
      .op_b    (opb),
      .done    (mul_done),
      .product (mul_p)
   );

   escu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (opa),
      .divisor  (opb),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = $signed(rsp_value_ff);
   assign rsp_status = rsp_status_ff;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the environmental sensor compensation unit.
`timescale 1ns / 1ps

class comp_scoreboard;
   logic [47:0]        temp_c, pa_c, pb_c, pc_c;
   logic [63:0]        hum_c;
   logic [31:0]        fine_t;
   logic signed [31:0] value_q[$];
   logic [1:0]         status_q[$];
   int                 errors;

   function new();
      temp_c = '0; pa_c = '0; pb_c = '0; pc_c = '0; hum_c = '0;
      fine_t = '0; errors = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
         escu_pkg::CSR_TEMP:    temp_c = d[47:0];
         escu_pkg::CSR_PRESS_A: pa_c = d[47:0];
         escu_pkg::CSR_PRESS_B: pb_c = d[47:0];
         escu_pkg::CSR_PRESS_C: pc_c = d[47:0];
         escu_pkg::CSR_HUM:     hum_c = d;
         default: ;
      endcase
   endfunction

   function logic [31:0] temperature(logic [23:0] raw);
      logic signed [31:0] t1, t2, t3, adc, a, d, b;
      t1 = {16'd0, temp_c[15:0]};
      t2 = $signed(temp_c[31:16]);
      t3 = $signed(temp_c[47:32]);
      adc = {12'd0, raw[23:4]};
      a = (((adc >>> 3) - (t1 <<< 1)) * t2) >>> 11;
      d = (adc >>> 4) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      fine_t = a + b;
      return ($signed(fine_t) * 5 + 128) >>> 8;
   endfunction

   function logic [1:0] pressure(logic [23:0] raw, output logic [31:0] v);
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, adc, v1, v2, p, num, q;
      logic [63:0] mn, md;
      p1 = {48'd0, pa_c[15:0]};
      p2 = $signed(pa_c[31:16]); p3 = $signed(pa_c[47:32]);
      p4 = $signed(pb_c[15:0]); p5 = $signed(pb_c[31:16]); p6 = $signed(pb_c[47:32]);
      p7 = $signed(pc_c[15:0]); p8 = $signed(pc_c[31:16]); p9 = $signed(pc_c[47:32]);
      adc = {44'd0, raw[23:4]};
      v1 = $signed(fine_t) - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      if (v1 == 0) begin
         v = '0;
         return escu_pkg::STATUS_DIV_ZERO;
      end
      p = 64'sd1048576 - adc;
      num = ((p <<< 31) - v2) * 3125;
      mn = num[63] ? -num : num;
      md = v1[63] ? -v1 : v1;
      q = mn / md;
      p = (num[63] != v1[63]) ? -q : q;
      v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
      v = p[31:0];
      return escu_pkg::STATUS_OK;
   endfunction

   function logic [31:0] humidity(logic [15:0] raw);
      logic signed [31:0] h1, h2, h3, h4, h5, h6, x, u1, u2, u3, u4, u5, s, adc;
      h1 = {24'd0, hum_c[7:0]}; h2 = $signed(hum_c[23:8]); h3 = {24'd0, hum_c[31:24]};
      h4 = $signed(hum_c[43:32]); h5 = $signed(hum_c[55:44]); h6 = $signed(hum_c[63:56]);
      adc = {16'd0, raw};
      x = $signed(fine_t) - 32'sd76800;
      u1 = ((adc <<< 14) - (h4 <<< 20) - h5 * x + 16384) >>> 15;
      u2 = (x * h6) >>> 10;
      u3 = ((x * h3) >>> 11) + 32768;
      u4 = ((u2 * u3) >>> 10) + 2097152;
      u5 = (u4 * h2 + 8192) >>> 14;
      x = u1 * u5;
      s = x >>> 15;
      x = x - ((((s * s) >>> 7) * h1) >>> 4);
      if (x < 0) x = 0;
      else if (x > 32'sd419430400) x = 32'sd419430400;
      return x >>> 12;
   endfunction

   function void note_request(logic [1:0] op, logic [23:0] raw);
      logic [31:0] v;
      logic [1:0]  st;
      v = '0; st = escu_pkg::STATUS_OK;
      case (op)
         escu_pkg::OP_TEMP:
            if (raw == escu_pkg::TP_SKIP_MARKER) st = escu_pkg::STATUS_DISABLED;
            else v = temperature(raw);
         escu_pkg::OP_PRESS:
            if (raw == escu_pkg::TP_SKIP_MARKER) st = escu_pkg::STATUS_DISABLED;
            else st = pressure(raw, v);
         escu_pkg::OP_HUM:
            if (raw[15:0] == escu_pkg::HUM_SKIP_MARKER) st = escu_pkg::STATUS_DISABLED;
            else v = humidity(raw[15:0]);
         default: ;
      endcase
      value_q.push_back(v);
      status_q.push_back(st);
   endfunction

   function void check_response(logic signed [31:0] v, logic [1:0] st);
      logic signed [31:0] ev;
      logic [1:0]         es;
      if (value_q.size() == 0) begin
         $display("%0t: unexpected response value %0d status %0d", $time, v, st);
         errors++;
         return;
      end
      ev = value_q.pop_front();
      es = status_q.pop_front();
      if (v !== ev) begin
         $display("%0t: value mismatch expected %0d actual %0d", $time, ev, v);
         errors++;
      end
      if (st !== es) begin
         $display("%0t: status mismatch expected %0d actual %0d", $time, es, st);
         errors++;
      end
   endfunction
endclass

module tb_top;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_op;
   logic [23:0]        req_raw_reading;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_value;
   logic [1:0]         rsp_status;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [63:0]        csr_wdata;

   comp_scoreboard sb;
   bit             hold_off;
   bit             stim_done;
   int             quiet_cycles;

   localparam int QUIET_LIMIT = 20000;

   environmental_sensor_compensation_unit u_dut (.*);

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [63:0] d);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= d;
      sb.write_reg(idx, d);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // The request stays up after acceptance until the next one or a gap replaces it;
   // the unit raises req_stall in the cycle after every acceptance.
   task automatic send_reading(logic [1:0] op, logic [23:0] raw, bit idle_ok);
      int g;
      g = idle_ok ? gap_len() : 0;
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1; req_op <= op; req_raw_reading <= raw;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, raw);
      @(negedge clock);
   endtask

   // Waits until every expected transaction has arrived, then lets the unit settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.value_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Calibration close to a real part, with a little random spread in the temperature coefficients.
   task automatic typical_coeffs();
      write_reg(escu_pkg::CSR_TEMP,
                64'({16'd50, 16'd26435, 16'd27504} + 48'($urandom_range(0, 63))));
      write_reg(escu_pkg::CSR_PRESS_A,
                64'({-16'sd2936 & 16'hFFFF, -16'sd10685 & 16'hFFFF, 16'd36477}));
      write_reg(escu_pkg::CSR_PRESS_B, 64'({16'sd23 - 16'sd0, 16'sd140, 16'sd2855}));
      write_reg(escu_pkg::CSR_PRESS_C, 64'({16'sd4285, -16'sd7 & 16'hFFFF, 16'sd15500}));
      write_reg(escu_pkg::CSR_HUM, {8'd30, 12'd50, 12'd312, 8'd0, 16'd363, 8'd75});
   endtask

   function automatic logic [23:0] rand_raw(logic [1:0] op);
      case ($urandom_range(0, 9))
         0: return escu_pkg::TP_SKIP_MARKER;
         1: return {8'($urandom()), escu_pkg::HUM_SKIP_MARKER};
         2: return $urandom_range(0, 1) ? 24'h000000 : 24'hFFFFFF;
         3, 4: return 24'($urandom());
         default: return (op == escu_pkg::OP_HUM)
                         ? {8'($urandom()), 16'($urandom_range(20000, 40000))}
                         : 24'($urandom_range(24'h400000, 24'h900000));
      endcase
   endfunction

   task automatic random_block(int n);
      logic [1:0] op;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(0, 19) == 0) ? escu_pkg::OP_NONE : 2'($urandom_range(0, 2));
         send_reading(op, rand_raw(op), 1'b1);
      end
   endtask

   initial begin
      sb = new();
      hold_off = 1'b0;
      reset = 1'b1; req_valid = 1'b0; req_op = '0; req_raw_reading = '0;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      stim_done = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Pressure and humidity before any temperature use a zero fine temperature;
      // with all-zero calibration the pressure divisor is zero.
      send_reading(escu_pkg::OP_PRESS, 24'h5A0000, 1'b0);
      send_reading(escu_pkg::OP_HUM, 24'h006000, 1'b0);
      drain();
      typical_coeffs();
      send_reading(escu_pkg::OP_PRESS, 24'h5A0000, 1'b0);
      send_reading(escu_pkg::OP_HUM, 24'hFF6000, 1'b0);
      send_reading(escu_pkg::OP_TEMP, 24'h7E0000, 1'b0);
      send_reading(escu_pkg::OP_TEMP, 24'h800000, 1'b0);
      send_reading(escu_pkg::OP_PRESS, 24'h800000, 1'b0);
      send_reading(escu_pkg::OP_HUM, 24'h7F8000, 1'b0);
      send_reading(escu_pkg::OP_HUM, 24'h008000, 1'b0);
      send_reading(escu_pkg::OP_TEMP, 24'h000000, 1'b0);
      send_reading(escu_pkg::OP_TEMP, 24'hFFFFFF, 1'b0);
      send_reading(escu_pkg::OP_PRESS, 24'h000000, 1'b0);
      send_reading(escu_pkg::OP_PRESS, 24'hFFFFFF, 1'b0);
      send_reading(escu_pkg::OP_HUM, 24'h000000, 1'b0);
      send_reading(escu_pkg::OP_HUM, 24'h00FFFF, 1'b0);
      send_reading(escu_pkg::OP_NONE, 24'hABCDEF, 1'b0);
      send_reading(escu_pkg::OP_TEMP, 24'h800010, 1'b0);
      send_reading(escu_pkg::OP_HUM, 24'h00FFFF, 1'b0);
      drain();

      // Extreme calibration: everything set, then 16'h8000 (the signed 16-bit minimum) in every 16-bit lane.
      for (int r = 0; r <= escu_pkg::CSR_HUM; r++) write_reg(3'(r), '1);
      random_block(20);
      drain();
      for (int r = 0; r <= escu_pkg::CSR_HUM; r++) write_reg(3'(r), 64'h8000_8000_8000_8000);
      random_block(20);
      drain();

      // Fully random calibration with random traffic.
      for (int k = 0; k < 6; k++) begin
         for (int r = 0; r <= escu_pkg::CSR_HUM; r++) write_reg(3'(r), rand64());
         random_block(60);
         drain();
      end

      // Realistic calibration: most of the run.
      typical_coeffs();
      fork
         random_block(1000);
         begin
            // Long hold-off on responses while readings keep coming.
            repeat (50) @(negedge clock);
            hold_off = 1'b1;
            repeat (2000) @(negedge clock);
            hold_off = 1'b0;
         end
      join
      drain();
      stim_done = 1'b1;
      if (sb.errors == 0 && sb.value_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Response side stall pattern.
   initial begin
      int g;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         g = gap_len();
         if (g != 0) begin
            rsp_stall <= 1'b1;
            repeat (g) @(negedge clock);
         end
         if (hold_off) begin
            rsp_stall <= 1'b1;
            while (hold_off) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_value, rsp_status);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_off)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (!stim_done && quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end
endmodule
